// File: design/form_urlencoded_pair_splitter_macros.svh
// ----------------------------------------------------------------------------
// Form URL-encoded pair splitter: assertion macros
// Shared concurrent assertion forms used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef FORM_URLENCODED_PAIR_SPLITTER_MACROS_SVH
`define FORM_URLENCODED_PAIR_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FUPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FUPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/fups_pkg.sv
// ----------------------------------------------------------------------------
// Form URL-encoded pair splitter package
// Payload types, result kinds, character codes, escape phases and hex helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fups_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Character codes that steer the decoder.
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Escape phases.
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    // Most results one input transaction can cause.
    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // All results caused by one input transaction.
    typedef struct packed {
        logic [2:0]                   count;
        t_out [MAX_RESULTS-1:0]       items;
    } t_batch;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c - 8'h30;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h57;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

// File: design/fups_step.sv
// ----------------------------------------------------------------------------
// Form URL-encoded pair splitter: decode step
// Holds the parse state and works out every result of one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fups_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire fups_pkg::t_in   i_item,
    output fups_pkg::t_batch     o_batch
);

    logic       r_value_part;
    logic [1:0] r_phase;
    logic [7:0] r_held;
    logic       n_value_part;
    logic [1:0] n_phase;
    logic [7:0] n_held;

    // Append one result to a batch, ignoring anything past the capacity.
    function automatic fups_pkg::t_batch push(input fups_pkg::t_batch b,
                                              input logic [1:0] kind,
                                              input logic [7:0] byt);
        fups_pkg::t_batch r;
        r = b;
        if (r.count != 3'(fups_pkg::MAX_RESULTS)) begin
            r.items[r.count[1:0]].out_kind = kind;
            r.items[r.count[1:0]].out_byte = byt;
            r.items[r.count[1:0]].out_last = 1'b0;
            r.count = r.count + 3'd1;
        end
        return r;
    endfunction

    // Result list and next state for the byte on the input.
    always_comb begin
        fups_pkg::t_batch b;
        logic             consumed;
        logic [1:0]       dk;
        logic [7:0]       c;

        b            = '0;
        consumed     = 1'b0;
        c            = i_item.in_byte;
        dk           = r_value_part ? fups_pkg::KIND_VALUE : fups_pkg::KIND_KEY;
        n_value_part = r_value_part;
        n_phase      = r_phase;
        n_held       = r_held;

        // Pending escape: complete it, or copy it through when the byte is not hex.
        if (r_phase != fups_pkg::ESC_NONE) begin
            if (fups_pkg::is_hex(c)) begin
                consumed = 1'b1;
                if (r_phase == fups_pkg::ESC_PCT) begin
                    n_phase = fups_pkg::ESC_DIGIT;
                    n_held  = c;
                end else begin
                    b       = push(b, dk, {fups_pkg::hex_val(r_held), fups_pkg::hex_val(c)});
                    n_phase = fups_pkg::ESC_NONE;
                    n_held  = 8'h00;
                end
            end else begin
                b = push(b, dk, fups_pkg::CHAR_PERCENT);
                if (r_phase == fups_pkg::ESC_DIGIT) begin
                    b = push(b, dk, r_held);
                end
                n_phase = fups_pkg::ESC_NONE;
                n_held  = 8'h00;
            end
        end

        // Ordinary handling of a byte that no escape took.
        if (!consumed) begin
            priority if (c == fups_pkg::CHAR_AMP) begin
                b            = push(b, fups_pkg::KIND_END, 8'h00);
                n_value_part = 1'b0;
            end else if ((c == fups_pkg::CHAR_EQUAL) && !r_value_part) begin
                n_value_part = 1'b1;
            end else if (c == fups_pkg::CHAR_PERCENT) begin
                n_phase = fups_pkg::ESC_PCT;
                n_held  = 8'h00;
            end else if (c == fups_pkg::CHAR_PLUS) begin
                b = push(b, dk, fups_pkg::CHAR_SPACE);
            end else begin
                b = push(b, dk, c);
            end
        end

        // End of query: flush the escape, close the pair and return to reset state.
        if (i_item.in_last) begin
            if (n_phase != fups_pkg::ESC_NONE) begin
                b = push(b, dk, fups_pkg::CHAR_PERCENT);
                if (n_phase == fups_pkg::ESC_DIGIT) begin
                    b = push(b, dk, n_held);
                end
            end
            if ((c != fups_pkg::CHAR_AMP) || consumed) begin
                b = push(b, fups_pkg::KIND_END, 8'h00);
            end
            if (b.count != 3'd0) begin
                b.items[2'(b.count - 3'd1)].out_last = 1'b1;
            end
            n_value_part = 1'b0;
            n_phase      = fups_pkg::ESC_NONE;
            n_held       = 8'h00;
        end

        o_batch = b;
    end

    // Parse state advances on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_part <= 1'b0;
            r_phase      <= fups_pkg::ESC_NONE;
            r_held       <= 8'h00;
        end else if (i_accept) begin
            r_value_part <= n_value_part;
            r_phase      <= n_phase;
            r_held       <= n_held;
        end
    end

endmodule

`default_nettype wire

// File: design/form_urlencoded_pair_splitter.sv
// ----------------------------------------------------------------------------
// Form URL-encoded pair splitter
// Splits a form-encoded query into key/value bytes and pair end markers.
// ----------------------------------------------------------------------------
// One raw query byte is taken per input transaction; it is decoded in the same
// cycle and its results (zero to four) are loaded into a result register bank,
// which hands them out one per output transaction. A new byte is accepted
// whenever the bank is empty or its last result leaves in that cycle, so a
// stream whose bytes each cause at most one result runs at one byte per clock
// while the output is ready. A byte that causes several results (a failed
// escape, or the end-of-query flush) holds the input until its last result
// leaves. Results keep the input order and the final result of the query carries out_last.
`default_nettype none

`include "form_urlencoded_pair_splitter_macros.svh"

module form_urlencoded_pair_splitter (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire fups_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output fups_pkg::t_out       o_out_data
);

    fups_pkg::t_batch                       w_batch;
    fups_pkg::t_out [fups_pkg::MAX_RESULTS-1:0] r_res;
    logic [2:0]                             r_rem;
    logic [1:0]                             r_idx;
    logic                                   w_in_acc;
    logic                                   w_out_acc;
    logic                                   w_drain_only;
    logic                                   w_last_out;
    logic                                   w_end_out;

    // Handshake: take a new byte once the bank drains this cycle.
    assign o_out_valid = (r_rem != 3'd0);
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_rem == 3'd0) || ((r_rem == 3'd1) && i_out_ready);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_data  = r_res[r_idx];

    fups_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_acc),
        .i_item   (i_in_data),
        .o_batch  (w_batch)
    );

    // Result bank: loaded per input transaction, drained per output transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
            r_idx <= 2'd0;
        end else if (w_in_acc) begin
            r_rem <= w_batch.count;
            r_idx <= 2'd0;
        end else if (w_out_acc) begin
            r_rem <= r_rem - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res <= w_batch.items;
        end
    end

    // Conditions watched by the checks below.
    assign w_drain_only = w_out_acc && !w_in_acc;
    assign w_last_out   = o_out_valid && o_out_data.out_last;
    assign w_end_out    = o_out_valid && (o_out_data.out_kind == fups_pkg::KIND_END);

    // Checks on the result bank.
    `FUPS_ASSERT_NOW(a_rem_bound, i_clk, i_rst_n, 1'b1, r_rem <= 3'(fups_pkg::MAX_RESULTS))
    `FUPS_ASSERT_NEXT(a_drain_step, i_clk, i_rst_n, w_drain_only, r_rem == $past(r_rem) - 3'd1)
    `FUPS_ASSERT_NOW(a_last_is_final, i_clk, i_rst_n, w_last_out, r_rem == 3'd1)
    `FUPS_ASSERT_NOW(a_end_zero, i_clk, i_rst_n, w_end_out, o_out_data.out_byte == 8'h00)

endmodule

`default_nettype wire
